// File: rtl/core/fplc_pkg.sv
// fplc_pkg: shared types and constants of the pair label count penalty core.
// No dependencies; imported by every module of the core.
package fplc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [15:0] OUT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		FN_ADD   = 2'd0,
		FN_REM   = 2'd1,
		FN_QUERY = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_QRY,
		ST_QWAIT
	} state_t;

	// classified work item; label and feature fields sized for the widest configuration
	typedef struct packed {
		func_t       op;
		logic [3:0]  label;
		logic [15:0] bits;
		logic [3:0]  fa;
		logic [3:0]  fb;
		logic [3:0]  lo;
		logic [3:0]  hi;
		logic        fa_oob;
		logic        fb_oob;
	} item_t;

endpackage

// File: rtl/core/fplc_front.sv
// fplc_front: classifies input beats, normalizes the queried pair, drops dead updates.
// Depends on fplc_pkg.
module fplc_front
	import fplc_pkg::*;
#(
	parameter int LABEL_COUNT   = 4,
	parameter int FEATURE_COUNT = 16
) (
	input  logic [1:0]  func,
	input  logic [1:0]  label,
	input  logic [15:0] present_features,
	input  logic [3:0]  feature_first,
	input  logic [3:0]  feature_second,
	output item_t       item,
	output logic        keep
);

	logic [4:0] lab5;
	logic [6:0] fa7;
	logic [6:0] fb7;
	logic [15:0] mask;

	assign lab5 = {3'b000, label};
	assign fa7  = {3'b000, feature_first};
	assign fb7  = {3'b000, feature_second};

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			mask[i] = (i < FEATURE_COUNT);
		end
	end

	always_comb begin
		item.op     = func_t'(func);
		item.label  = {2'b00, label};
		item.bits   = present_features & mask;
		item.fa     = feature_first;
		item.fb     = feature_second;
		item.lo     = (feature_first < feature_second) ? feature_first : feature_second;
		item.hi     = (feature_first < feature_second) ? feature_second : feature_first;
		item.fa_oob = (fa7 >= 7'(FEATURE_COUNT));
		item.fb_oob = (fb7 >= 7'(FEATURE_COUNT));
		keep = 1'b1;
		if ((item.op == FN_ADD || item.op == FN_REM) && lab5 >= 5'(LABEL_COUNT)) begin
			keep = 1'b0;
		end
	end

endmodule

// File: rtl/core/fplc_queue.sv
// fplc_queue: short item queue between front and back.
// Depends on fplc_pkg.
module fplc_queue
	import fplc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t      mem_q [QUEUE_DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/core/fplc_back.sv
// fplc_back: count store, update sweep, query sequencer and result register.
// Depends on fplc_pkg.
module fplc_back
	import fplc_pkg::*;
#(
	parameter int LABEL_COUNT   = 4,
	parameter int FEATURE_COUNT = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  labels_in_use,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] penalty_one_one,
	output logic [15:0] penalty_one_zero,
	output logic [15:0] penalty_zero_one,
	output logic [15:0] penalty_zero_zero
);

	localparam int NFE   = (FEATURE_COUNT < 16) ? FEATURE_COUNT : 16;
	localparam int FW    = $clog2(NFE);
	localparam int LW    = $clog2(LABEL_COUNT);
	localparam int AW    = LW + 2 * FW;
	localparam int DEPTH = LABEL_COUNT << (2 * FW);
	localparam int SW0   = COUNT_WIDTH + LW + 1;
	localparam int SW    = (SW0 > 17) ? SW0 : 17;
	localparam int CW    = COUNT_WIDTH;
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	state_t state_q, state_d;

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	item_t         cur_q;
	logic [FW-1:0] pa_q, pb_q;
	logic [LW-1:0] qlab_q;
	logic [1:0]    qk_q;
	logic [AW-1:0] clr_q;

	logic          wr_en_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          tv_s1, tlast_s1, tfirst_s1;
	logic [1:0]    tk_s1;
	logic [LW-1:0] tlab_s1;

	logic [CW-1:0] both_q, s1_q;
	logic [SW-1:0] sum_q  [4];
	logic [CW-1:0] best_q [4];
	logic          fin_q;
	logic [CW-1:0] tot_q  [LABEL_COUNT];
	logic [LW-1:0] tot_idx;
	logic          out_valid_q;
	logic [15:0]   pen_q [4];

	logic [4:0]    cfg5, um5;
	logic [LW-1:0] used_m1;
	logic          upd_last, qry_last, upd_en;
	logic [CW-1:0] s2v;
	logic [CW-1:0] v [4];
	logic [CW+2:0] t3;

	function automatic logic [CW-1:0] bump(input logic [CW-1:0] x, input logic down);
		if (down) return (x != '0) ? x - 1'b1 : x;
		return (x != CMAX) ? x + 1'b1 : x;
	endfunction

	assign cfg5 = {2'b00, labels_in_use};
	assign um5  = (cfg5 == 5'd0) ? 5'd0 :
	              (cfg5 > 5'(LABEL_COUNT)) ? 5'(LABEL_COUNT - 1) : cfg5 - 5'd1;
	assign used_m1 = um5[LW-1:0];

	assign upd_last = (pa_q == FW'(NFE - 1)) && (pb_q == FW'(NFE - 1));
	assign qry_last = (qlab_q == used_m1) && (qk_q == 2'd2);
	assign upd_en   = cur_q.bits[pa_q] & cur_q.bits[pb_q];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (pop) begin
					case (head.op)
						FN_CLEAR: state_d = ST_CLEAR;
						FN_QUERY: state_d = ST_QRY;
						default:  state_d = ST_UPD;
					endcase
				end
			end
			ST_UPD:   if (upd_last) state_d = ST_IDLE;
			ST_QRY:   if (qry_last) state_d = ST_QWAIT;
			ST_QWAIT: if (fin_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = (state_q == ST_IDLE) && head_valid && (head.op != FN_QUERY || !out_valid_q);
		tot_idx = (state_q == ST_QRY || state_q == ST_QWAIT) ? tlab_s1 : head.label[LW-1:0];
		case (state_q)
			ST_QRY: begin
				case (qk_q)
					2'd0:    rd_addr = {qlab_q, cur_q.lo[FW-1:0], cur_q.hi[FW-1:0]};
					2'd1:    rd_addr = {qlab_q, cur_q.fa[FW-1:0], cur_q.fa[FW-1:0]};
					default: rd_addr = {qlab_q, cur_q.fb[FW-1:0], cur_q.fb[FW-1:0]};
				endcase
			end
			default: rd_addr = {cur_q.label[LW-1:0], pa_q, pb_q};
		endcase
	end

	// per-label derived counts
	always_comb begin
		s2v  = cur_q.fb_oob ? '0 : rd_data_q;
		v[0] = both_q;
		v[1] = (s1_q >= both_q) ? s1_q - both_q : '0;
		v[2] = (s2v >= both_q) ? s2v - both_q : '0;
		t3   = {3'b000, tot_q[tot_idx]} - {3'b000, s1_q} - {3'b000, s2v} + {3'b000, both_q};
		if (t3[CW+2]) v[3] = '0;
		else if (t3[CW+1:CW] != 2'b00) v[3] = CMAX;
		else v[3] = t3[CW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (wr_en_s1) begin
			mem[wr_addr_s1] <= bump(rd_data_q, cur_q.op == FN_REM);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= rd_addr;
		tk_s1      <= qk_q;
		tlab_s1    <= qlab_q;
		tlast_s1   <= qry_last;
		tfirst_s1  <= (qlab_q == '0);
		if (pop) cur_q <= head;
		if (tv_s1 && tk_s1 == 2'd0) both_q <= (cur_q.fa_oob || cur_q.fb_oob) ? '0 : rd_data_q;
		if (tv_s1 && tk_s1 == 2'd1) s1_q <= cur_q.fa_oob ? '0 : rd_data_q;
		if (tv_s1 && tk_s1 == 2'd2) begin
			for (int k = 0; k < 4; k++) begin
				if (tfirst_s1) begin
					sum_q[k]  <= {{(SW - CW){1'b0}}, v[k]};
					best_q[k] <= v[k];
				end else begin
					sum_q[k] <= sum_q[k] + {{(SW - CW){1'b0}}, v[k]};
					if (v[k] > best_q[k]) best_q[k] <= v[k];
				end
			end
		end
		if (state_q == ST_QWAIT && fin_q) begin
			for (int k = 0; k < 4; k++) begin
				logic [SW-1:0] p;
				p = sum_q[k] - {{(SW - CW){1'b0}}, best_q[k]};
				pen_q[k] <= (p > SW'(OUT_MAX)) ? OUT_MAX : p[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pa_q        <= '0;
			pb_q        <= '0;
			qlab_q      <= '0;
			qk_q        <= 2'd0;
			wr_en_s1    <= 1'b0;
			tv_s1       <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int l = 0; l < LABEL_COUNT; l++) tot_q[l] <= '0;
		end else begin
			state_q  <= state_d;
			wr_en_s1 <= (state_q == ST_UPD) && upd_en;
			tv_s1    <= (state_q == ST_QRY);
			fin_q    <= tv_s1 && (tk_s1 == 2'd2) && tlast_s1;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (pop) begin
				pa_q   <= '0;
				pb_q   <= '0;
				qlab_q <= '0;
				qk_q   <= 2'd0;
				clr_q  <= '0;
				if (head.op == FN_CLEAR) begin
					for (int l = 0; l < LABEL_COUNT; l++) tot_q[l] <= '0;
				end else if (head.op != FN_QUERY) begin
					tot_q[tot_idx] <= bump(tot_q[tot_idx], head.op == FN_REM);
				end
			end
			if (state_q == ST_UPD) begin
				if (pb_q == FW'(NFE - 1)) begin
					pa_q <= pa_q + 1'b1;
					pb_q <= pa_q + 1'b1;
				end else begin
					pb_q <= pb_q + 1'b1;
				end
			end
			if (state_q == ST_QRY) begin
				if (qk_q == 2'd2) begin
					qk_q   <= 2'd0;
					qlab_q <= qlab_q + 1'b1;
				end else begin
					qk_q <= qk_q + 2'd1;
				end
			end
			if (state_q == ST_QWAIT && fin_q) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign penalty_one_one   = pen_q[0];
	assign penalty_one_zero  = pen_q[1];
	assign penalty_zero_one  = pen_q[2];
	assign penalty_zero_zero = pen_q[3];

endmodule

// File: rtl/core/feature_pair_label_count_penalty_core.sv
// Pair label count penalty core: front classifier, item queue and count back end.
// Depends on fplc_pkg, fplc_front, fplc_queue, fplc_back.
//
// Input channel (in_valid/in_ready) takes one beat per item: add, remove, query
// or clear. Output channel (out_valid/out_ready) returns one beat of four
// penalties per query; other items give no beat. cfg_we/cfg_wdata write
// labels_in_use; the user must write it only while the core is idle, unchecked.
// The front takes a beat whenever the two-entry queue has room; updates with a
// label at or beyond LABEL_COUNT are dropped there.
// An add or remove sweeps all NF*(NF+1)/2 feature pairs of its label in the
// count memory, one read-modify-write per cycle. A query reads three counters
// per label in use. A clear, and reset, sweep the whole count memory of
// LABEL_COUNT*2^(2*ceil(log2(NF))) entries, 1024 at the defaults, one entry a
// cycle, during which no item is carried out.
// The result sits in an output register; while it waits for out_ready, later
// updates still run, and the next query waits until the register is taken.
module feature_pair_label_count_penalty_core
	import fplc_pkg::*;
#(
	parameter int LABEL_COUNT   = 4,
	parameter int FEATURE_COUNT = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [1:0]  label,
	input  logic [15:0] present_features,
	input  logic [3:0]  feature_first,
	input  logic [3:0]  feature_second,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] penalty_one_one,
	output logic [15:0] penalty_one_zero,
	output logic [15:0] penalty_zero_one,
	output logic [15:0] penalty_zero_zero,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	item_t      fr_item, hd_item;
	logic       fr_keep, q_full, hd_valid, hd_pop;
	logic [2:0] labels_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			labels_in_use_q <= 3'd2;
		end else if (cfg_we) begin
			labels_in_use_q <= cfg_wdata;
		end
	end

	assign in_ready = !q_full;

	fplc_front #(
		.LABEL_COUNT  (LABEL_COUNT),
		.FEATURE_COUNT(FEATURE_COUNT)
	) u_front (
		.func            (func),
		.label           (label),
		.present_features(present_features),
		.feature_first   (feature_first),
		.feature_second  (feature_second),
		.item            (fr_item),
		.keep            (fr_keep)
	);

	fplc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready && fr_keep),
		.push_item (fr_item),
		.full      (q_full),
		.pop       (hd_pop),
		.head_valid(hd_valid),
		.head      (hd_item)
	);

	fplc_back #(
		.LABEL_COUNT  (LABEL_COUNT),
		.FEATURE_COUNT(FEATURE_COUNT),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.labels_in_use    (labels_in_use_q),
		.head_valid       (hd_valid),
		.head             (hd_item),
		.pop              (hd_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.penalty_one_one  (penalty_one_one),
		.penalty_one_zero (penalty_one_zero),
		.penalty_zero_one (penalty_zero_one),
		.penalty_zero_zero(penalty_zero_zero)
	);

endmodule
